>>> hw/rtl/ci2rs_pkg.sv
// ----------------------------------------------------------------------------
// ci2rs_pkg: shared types and constants for the radix string converter
// Digit store depth, status codes and controller/datapath command structs.
// ----------------------------------------------------------------------------
package ci2rs_pkg;

	localparam int unsigned MaxDigits = 64;
	localparam int unsigned DigW      = 6;
	localparam int unsigned CntW      = 7;

	localparam logic [1:0] StatusOk       = 2'd0;
	localparam logic [1:0] StatusInvalid  = 2'd1;
	localparam logic [1:0] StatusRangeErr = 2'd2;

	localparam logic [6:0] CharMinus = 7'h2d;
	localparam logic [6:0] CharZero  = 7'h30;
	localparam logic [6:0] CharAlpha = 7'h57; // 'a' - 10

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request, start division
		logic div_start; // start a new digit division
		logic emit_load; // load the output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_busy;
		logic div_done;    // digit division finished this cycle
		logic more_digits; // quotient nonzero and store not full
		logic seq_done;    // current emit item is the last one
		logic emit_ready;  // digit for the current item has been read
	} dp_stat_t;

	function automatic logic [6:0] digit_char(input logic [5:0] d);
		logic [6:0] r;
		r = {1'b0, d};
		if (d <= 6'd9) return CharZero + r;
		return CharAlpha + r;
	endfunction

endpackage

>>> hw/rtl/ci2rs_ctrl.sv
// ----------------------------------------------------------------------------
// ci2rs_ctrl: request sequencer
// Steps a request through capture, digit division and cell write emission.
// ----------------------------------------------------------------------------
module ci2rs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	input  logic                out_full,
	output ci2rs_pkg::dp_cmd_t  cmd,
	input  ci2rs_pkg::dp_stat_t stat
);
	import ci2rs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_WAIT = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   emit_ok;

	assign in_ready = (state_q == S_IDLE);
	assign emit_ok  = stat.emit_ready && (!out_full || out_ready);

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.div_start = 1'b0;
		cmd.emit_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					if (stat.more_digits) cmd.div_start = 1'b1;
					else state_d = S_EMIT;
				end else if (!stat.div_busy) begin
					// argument errors skip the divider
					state_d = S_EMIT;
				end
			end
			S_WAIT: state_d = S_EMIT;
			S_EMIT: begin
				if (emit_ok) begin
					cmd.emit_load = 1'b1;
					if (stat.seq_done) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

>>> hw/rtl/ci2rs_dp.sv
// ----------------------------------------------------------------------------
// ci2rs_dp: conversion datapath
// Restoring radix divider, digit store and the cell write output register.
// ----------------------------------------------------------------------------
module ci2rs_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [63:0]         value,
	input  logic                buffer_present,
	input  logic [15:0]         buffer_size,
	input  logic [7:0]          radix,
	input  logic                out_ready,
	input  ci2rs_pkg::dp_cmd_t  cmd,
	output ci2rs_pkg::dp_stat_t stat,
	output logic                out_full,
	output logic                write_valid,
	output logic [5:0]          cell_index,
	output logic [6:0]          cell_char,
	output logic                terminate_next,
	output logic [1:0]          status,
	output logic                handler_fired,
	output logic                last
);
	import ci2rs_pkg::*;

	// request mode after capture
	typedef enum logic [2:0] {
		M_SINGLE = 3'b001,
		M_OK     = 3'b010,
		M_RANGE  = 3'b100
	} mode_t;

	logic [63:0] quot_q;   // remaining magnitude / quotient being built
	logic [5:0]  rem_q;
	logic [5:0]  radix_q;
	logic [6:0]  bit_q;    // bits left in current division
	logic        div_busy_q;
	logic [CntW-1:0] ndig_q;
	logic        neg_q;
	logic [15:0] size_q;
	mode_t       mode_q;
	logic [1:0]  single_st_q;
	logic        single_wv_q;
	logic [6:0]  emit_i_q;  // emit item counter
	logic [5:0]  store_mem [MaxDigits];
	logic [5:0]  rd_q;
	logic        rd_ok_q;

	// single-item outcomes from the arguments
	logic        a_neg, a_badarg, a_small, a_badradix;
	assign a_neg      = (radix == 8'd10) && value[63];
	assign a_badarg   = !buffer_present || (buffer_size == 16'd0);
	assign a_small    = buffer_size <= {15'd0, a_neg} + 16'd1;
	assign a_badradix = (radix < 8'd2) || (radix > 8'd36);

	// one restoring step per cycle
	logic [6:0] trial;
	logic       ge;
	assign trial = {rem_q, quot_q[63]};
	assign ge    = trial >= {1'b0, radix_q};

	logic div_done;
	assign div_done = div_busy_q && (bit_q == 7'd1);

	logic [63:0] quot_next;
	assign quot_next = {quot_q[62:0], ge};

	logic [CntW-1:0] ndig_next;
	assign ndig_next = ndig_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			bit_q      <= '0;
			ndig_q     <= '0;
			quot_q     <= '0;
			mode_q     <= M_SINGLE;
		end else begin
			if (cmd.load) begin
				neg_q       <= a_neg;
				size_q      <= buffer_size;
				radix_q     <= radix[5:0];
				ndig_q      <= '0;
				rem_q       <= '0;
				quot_q      <= a_neg ? 64'd0 - value : value;
				single_wv_q <= !a_badarg;
				single_st_q <= (a_badarg || !a_small) ? StatusInvalid : StatusRangeErr;
				if (a_badarg || a_small || a_badradix) begin
					mode_q     <= M_SINGLE;
					div_busy_q <= 1'b0;
				end else begin
					mode_q     <= M_OK;
					div_busy_q <= 1'b1;
					bit_q      <= 7'd64;
				end
			end else if (div_busy_q) begin
				quot_q <= quot_next;
				if (div_done) begin
					// the next digit division starts right away when requested
					div_busy_q <= cmd.div_start;
					bit_q      <= 7'd64;
					rem_q      <= '0;
					ndig_q     <= ndig_next;
					if ({9'd0, {1'b0, neg_q} + ndig_next} + 16'd1 > size_q) mode_q <= M_RANGE;
					else mode_q <= M_OK;
				end else begin
					rem_q <= ge ? 6'(trial - {1'b0, radix_q}) : trial[5:0];
					bit_q <= bit_q - 1'b1;
				end
			end
		end
	end

	// digit store write on each finished division
	logic [5:0] fin_rem;
	assign fin_rem = ge ? 6'(trial - {1'b0, radix_q}) : trial[5:0];
	always_ff @(posedge clk) begin
		if (div_done) store_mem[ndig_q[5:0]] <= fin_rem;
	end

	assign stat.div_busy    = div_busy_q;
	assign stat.div_done    = div_done;
	assign stat.more_digits = (quot_next != 64'd0) && (ndig_next < CntW'(MaxDigits));

	// emission: index of the digit needed by item e, read ahead into a register
	logic [6:0] total;        // items in the sequence
	logic [6:0] e_next;
	logic [6:0] rd_pos;
	logic       rd_valid;
	assign total = (mode_q == M_SINGLE) ? 7'd1 :
		(mode_q == M_OK) ? {6'd0, neg_q} + ndig_q : size_q[6:0];

	// read position for item e: ok mode -> nd-1-(e-neg); range -> e-neg
	function automatic logic [6:0] pos_of(input logic [6:0] e);
		logic [6:0] p;
		p = e - {6'd0, neg_q};
		if (mode_q == M_OK) return ndig_q - 7'd1 - p;
		return p;
	endfunction

	logic emitting_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) emitting_q <= 1'b0;
		else emitting_q <= !cmd.load && !div_busy_q && !cmd.div_start;
	end

	// prefetch the digit for the current item
	assign e_next   = emitting_q ? emit_i_q : 7'd0;
	assign rd_pos   = pos_of(e_next);
	assign rd_valid = (rd_pos < ndig_q);
	always_ff @(posedge clk) begin
		rd_q    <= store_mem[rd_pos[5:0]];
		rd_ok_q <= rd_valid;
	end

	logic rd_ready_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_i_q   <= '0;
			rd_ready_q <= 1'b0;
		end else begin
			if (cmd.load || div_busy_q || cmd.div_start) begin
				emit_i_q   <= '0;
				rd_ready_q <= 1'b0;
			end else if (cmd.emit_load) begin
				emit_i_q   <= emit_i_q + 1'b1;
				rd_ready_q <= 1'b0;
			end else begin
				rd_ready_q <= 1'b1;
			end
		end
	end

	logic is_last;
	assign is_last         = (emit_i_q + 7'd1 == total);
	assign stat.seq_done   = is_last;
	assign stat.emit_ready = rd_ready_q;

	// output register
	logic full_q;
	assign out_full = full_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) full_q <= 1'b0;
		else if (cmd.emit_load) full_q <= 1'b1;
		else if (out_ready) full_q <= 1'b0;
	end

	logic [5:0] dsel;
	assign dsel = rd_ok_q ? rd_q : 6'd0;
	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			last <= is_last;
			case (mode_q)
				M_SINGLE: begin
					write_valid    <= single_wv_q;
					cell_index     <= '0;
					cell_char      <= '0;
					terminate_next <= 1'b0;
					status         <= single_st_q;
					handler_fired  <= 1'b1;
				end
				M_OK: begin
					write_valid    <= 1'b1;
					cell_index     <= emit_i_q[5:0];
					cell_char      <= (neg_q && emit_i_q == 7'd0) ? CharMinus : digit_char(dsel);
					terminate_next <= is_last;
					status         <= StatusOk;
					handler_fired  <= 1'b0;
				end
				default: begin
					write_valid    <= 1'b1;
					cell_index     <= emit_i_q[5:0];
					cell_char      <= (emit_i_q == 7'd0) ? 7'd0 : digit_char(dsel);
					terminate_next <= 1'b0;
					status         <= is_last ? StatusRangeErr : StatusOk;
					handler_fired  <= is_last;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/checked_int64_to_radix_string.sv
// ----------------------------------------------------------------------------
// checked_int64_to_radix_string: checked 64-bit integer to radix string
// Emits the buffer cell writes for one formatted value per transaction.
// Each digit comes from a restoring divider (one quotient bit a cycle);
// the cell writes are emitted after the last digit. Argument errors skip
// the divider and emit a single item.
// Throughput: one request at a time, next accepted after the last cell write.
// Reset: arst_n clears the sequencer and output valid; digit store is unset.
// ----------------------------------------------------------------------------
module checked_int64_to_radix_string (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] value,
	input  logic        buffer_present,
	input  logic [15:0] buffer_size,
	input  logic [7:0]  radix,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        write_valid,
	output logic [5:0]  cell_index,
	output logic [6:0]  cell_char,
	output logic        terminate_next,
	output logic [1:0]  status,
	output logic        handler_fired,
	output logic        last
);
	import ci2rs_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     out_full;
	logic     valid_q;

	ci2rs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_ready(out_ready),
		.out_full (out_full),
		.cmd      (cmd),
		.stat     (stat)
	);

	ci2rs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.value         (value),
		.buffer_present(buffer_present),
		.buffer_size   (buffer_size),
		.radix         (radix),
		.out_ready     (out_ready),
		.cmd           (cmd),
		.stat          (stat),
		.out_full      (out_full),
		.write_valid   (write_valid),
		.cell_index    (cell_index),
		.cell_char     (cell_char),
		.terminate_next(terminate_next),
		.status        (status),
		.handler_fired (handler_fired),
		.last          (last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (cmd.emit_load) valid_q <= 1'b1;
		else if (out_ready) valid_q <= 1'b0;
	end
	assign out_valid = valid_q;

endmodule
